FILE: rtl/core/dhcp_option_lease_extractor_assert.svh
// Assertion macros shared by the DHCP option lease extractor modules.
`ifndef DHCP_OPTION_LEASE_EXTRACTOR_ASSERT_SVH
`define DHCP_OPTION_LEASE_EXTRACTOR_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define DOLX_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("dolx assertion failed");

// Antecedent implies consequent in the same cycle.
`define DOLX_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dolx assertion failed");

// Antecedent implies consequent in the next cycle.
`define DOLX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dolx assertion failed");

`endif

FILE: rtl/core/dolx_pkg.sv
// Shared types, option codes and helper functions of the DHCP option lease extractor.
package dolx_pkg;

  // Parser phase, one-hot
  typedef enum logic [3:0] {
    PH_CODE  = 4'b0001,
    PH_LEN   = 4'b0010,
    PH_VALUE = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_t;

  // Option codes
  localparam logic [7:0] CODE_PAD    = 8'd0;
  localparam logic [7:0] CODE_MASK   = 8'd1;
  localparam logic [7:0] CODE_ROUTER = 8'd3;
  localparam logic [7:0] CODE_DNS    = 8'd6;
  localparam logic [7:0] CODE_TIME   = 8'd42;
  localparam logic [7:0] CODE_LEASE  = 8'd51;
  localparam logic [7:0] CODE_END    = 8'd255;

  // Seen-option flag bits
  localparam logic [4:0] FLAG_MASK   = 5'b00001;
  localparam logic [4:0] FLAG_ROUTER = 5'b00010;
  localparam logic [4:0] FLAG_DNS    = 5'b00100;
  localparam logic [4:0] FLAG_TIME   = 5'b01000;
  localparam logic [4:0] FLAG_LEASE  = 5'b10000;

  // Address bytes kept per option; value index saturates here
  localparam logic [2:0] ADDR_BYTES = 3'd4;

  // One options byte handed from the input register to the parser
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
    logic       last;
  } step_t;

  // Stored values reported on the last byte
  typedef struct packed {
    logic [31:0] mask;
    logic [31:0] router;
    logic [31:0] dns;
    logic [31:0] tsrv;
    logic [31:0] lease;
    logic [4:0]  found;
  } result_t;

  // Flag bit of a kept option, zero for any other code
  function automatic logic [4:0] flag_of(input logic [7:0] code);
    logic [4:0] f;
    unique case (code)
      CODE_MASK:   f = FLAG_MASK;
      CODE_ROUTER: f = FLAG_ROUTER;
      CODE_DNS:    f = FLAG_DNS;
      CODE_TIME:   f = FLAG_TIME;
      CODE_LEASE:  f = FLAG_LEASE;
      default:     f = 5'b00000;
    endcase
    return f;
  endfunction

  // Overwrite one byte of an address, index 0 is the most significant
  function automatic logic [31:0] put_byte(input logic [31:0] word, input logic [1:0] idx,
                                           input logic [7:0] b);
    logic [31:0] w;
    w = word;
    unique case (idx)
      2'd0: w[31:24] = b;
      2'd1: w[23:16] = b;
      2'd2: w[15:8]  = b;
      2'd3: w[7:0]   = b;
      default: w = word;
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/core/dolx_in_reg.sv
// Input register: captures one options word and holds it until the parser can take it.
module dolx_in_reg
  import dolx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_opt_byte,
  input  logic       in_last_byte,
  input  logic       out_busy,
  output step_t      step
);

  logic       vld_r, vld_nxt;
  logic [7:0] data_r;
  logic       last_r;
  logic       can_proc;
  logic       accept;

  // A last word needs the result register; other words always move on
  assign can_proc = vld_r && !(last_r && out_busy);
  assign in_stall = vld_r && !can_proc;
  assign accept   = in_valid && !in_stall;

  assign vld_nxt = accept ? 1'b1 : (can_proc ? 1'b0 : vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= in_opt_byte;
      last_r <= in_last_byte;
    end
  end

  assign step.vld  = can_proc;
  assign step.data = data_r;
  assign step.last = last_r;

endmodule

FILE: rtl/core/dolx_parser.sv
// Option record walker: parse state, seen flags and the persistent value stores.
`include "dhcp_option_lease_extractor_assert.svh"

module dolx_parser
  import dolx_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  step_t   step,
  output logic    res_fire,
  output result_t res
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  code_r, code_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [4:0]  seen_r, seen_nxt;
  logic [31:0] mask_r, mask_nxt;
  logic [31:0] router_r, router_nxt;
  logic [31:0] dns_r, dns_nxt;
  logic [31:0] tsrv_r, tsrv_nxt;
  logic [31:0] lease_r, lease_nxt;
  logic [4:0]  flag;

  assign flag = flag_of(step.data);

  // One record step per word
  always_comb begin
    phase_nxt  = phase_r;
    code_nxt   = code_r;
    left_nxt   = left_r;
    idx_nxt    = idx_r;
    seen_nxt   = seen_r;
    mask_nxt   = mask_r;
    router_nxt = router_r;
    dns_nxt    = dns_r;
    tsrv_nxt   = tsrv_r;
    lease_nxt  = lease_r;
    res_fire   = 1'b0;
    res        = '0;
    if (step.vld) begin
      unique case (phase_r)
        PH_CODE: begin
          if (step.data == CODE_END) begin
            phase_nxt = PH_DONE;
          end else if (step.data != CODE_PAD) begin
            // only the first record of a kept code is stored
            if ((flag != 5'b00000) && ((seen_r & flag) == 5'b00000)) begin
              seen_nxt = seen_r | flag;
              code_nxt = step.data;
            end else begin
              code_nxt = CODE_PAD;
            end
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          left_nxt = step.data;
          idx_nxt  = 3'd0;
          if (code_r == CODE_LEASE) begin
            lease_nxt = 32'd0;
          end
          phase_nxt = (step.data == 8'd0) ? PH_CODE : PH_VALUE;
        end
        PH_VALUE: begin
          if (code_r == CODE_LEASE) begin
            lease_nxt = {lease_r[23:0], step.data};
          end else if (idx_r < ADDR_BYTES) begin
            unique case (code_r)
              CODE_MASK:   mask_nxt   = put_byte(mask_r, idx_r[1:0], step.data);
              CODE_ROUTER: router_nxt = put_byte(router_r, idx_r[1:0], step.data);
              CODE_DNS:    dns_nxt    = put_byte(dns_r, idx_r[1:0], step.data);
              CODE_TIME:   tsrv_nxt   = put_byte(tsrv_r, idx_r[1:0], step.data);
              default:     mask_nxt   = mask_r;
            endcase
          end
          if (idx_r < ADDR_BYTES) begin
            idx_nxt = idx_r + 3'd1;
          end
          left_nxt = left_r - 8'd1;
          if (left_r == 8'd1) begin
            phase_nxt = PH_CODE;
          end
        end
        PH_DONE: begin
          phase_nxt = PH_DONE;
        end
        default: begin
          phase_nxt = PH_CODE;
        end
      endcase

      // Report on the last word, then start over for the next packet
      if (step.last) begin
        res_fire   = 1'b1;
        res.mask   = mask_nxt;
        res.router = router_nxt;
        res.dns    = dns_nxt;
        res.tsrv   = tsrv_nxt;
        res.lease  = lease_nxt;
        res.found  = seen_nxt;
        phase_nxt  = PH_CODE;
        code_nxt   = CODE_PAD;
        left_nxt   = 8'd0;
        idx_nxt    = 3'd0;
        seen_nxt   = 5'b00000;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_CODE;
      code_r   <= CODE_PAD;
      left_r   <= 8'd0;
      idx_r    <= 3'd0;
      seen_r   <= 5'b00000;
      mask_r   <= 32'd0;
      router_r <= 32'd0;
      dns_r    <= 32'd0;
      tsrv_r   <= 32'd0;
      lease_r  <= 32'd0;
    end else begin
      phase_r  <= phase_nxt;
      code_r   <= code_nxt;
      left_r   <= left_nxt;
      idx_r    <= idx_nxt;
      seen_r   <= seen_nxt;
      mask_r   <= mask_nxt;
      router_r <= router_nxt;
      dns_r    <= dns_nxt;
      tsrv_r   <= tsrv_nxt;
      lease_r  <= lease_nxt;
    end
  end

  // Checks
  `DOLX_ASSERT_NEXT(a_clear_after_last, res_fire, (phase_r == PH_CODE) && (seen_r == 5'b00000))
  `DOLX_ASSERT_IMPL(a_code_is_seen, code_r != CODE_PAD, (seen_r & flag_of(code_r)) != 5'b00000)
  `DOLX_ASSERT_IMPL(a_value_has_bytes, phase_r == PH_VALUE, left_r != 8'd0)

endmodule

FILE: rtl/core/dolx_out_reg.sv
// Result register: derives T1 and T2 from the lease and holds the result word.
`include "dhcp_option_lease_extractor_assert.svh"

module dolx_out_reg
  import dolx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        res_fire,
  input  result_t     res,
  output logic        out_busy,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_subnet_mask,
  output logic [31:0] out_router_addr,
  output logic [31:0] out_dns_addr,
  output logic [31:0] out_time_server_addr,
  output logic [31:0] out_lease_seconds,
  output logic [30:0] out_renew_seconds,
  output logic [31:0] out_rebind_seconds,
  output logic [4:0]  out_found_mask
);

  logic        valid_r, valid_nxt;
  logic [34:0] seven_eighths;
  logic [31:0] mask_r, router_r, dns_r, tsrv_r, lease_r, rebind_r;
  logic [30:0] renew_r;
  logic [4:0]  found_r;

  // 7 * lease as 8 * lease - lease, then drop three bits
  assign seven_eighths = {res.lease, 3'b000} - {3'b000, res.lease};

  assign out_busy  = valid_r && out_stall;
  assign valid_nxt = res_fire || out_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk) begin
    if (res_fire) begin
      mask_r   <= res.mask;
      router_r <= res.router;
      dns_r    <= res.dns;
      tsrv_r   <= res.tsrv;
      lease_r  <= res.lease;
      renew_r  <= res.lease[31:1];
      rebind_r <= seven_eighths[34:3];
      found_r  <= res.found;
    end
  end

  assign out_valid            = valid_r;
  assign out_subnet_mask      = mask_r;
  assign out_router_addr      = router_r;
  assign out_dns_addr         = dns_r;
  assign out_time_server_addr = tsrv_r;
  assign out_lease_seconds    = lease_r;
  assign out_renew_seconds    = renew_r;
  assign out_rebind_seconds   = rebind_r;
  assign out_found_mask       = found_r;

  // Checks
  `DOLX_ASSERT_NEXT(a_held_while_stalled, out_busy, valid_r)
  `DOLX_ASSERT_ALWAYS(a_no_overwrite, !(res_fire && out_busy))

endmodule

FILE: rtl/core/dhcp_option_lease_extractor.sv
// Top level of the DHCP option lease extractor.
//
// Input channel: one options byte per word (in_opt_byte), in_last_byte marks the
// final byte of a packet. A word moves when in_valid is high and in_stall low.
// Result channel: one word per packet, issued for the last byte, carrying the
// stored mask, router, DNS and time server addresses, the lease, T1 = lease/2,
// T2 = floor(7*lease/8) and the mask of options seen in this packet.
// Throughput: one byte per cycle unless a last byte waits on a held result; the
// record walk is a single register update per byte.
// Result path: the last byte passes the input register, then the result register;
// it waits in the input register while a held result blocks the result register.
// Receiver stall: a held result keeps its word; non-final bytes keep flowing,
// and only a following last byte waits in the input register, which then
// raises in_stall until the result register frees.
// Reset (rst_n low, synchronous): parse state returns to PH_CODE; seen flags and
// all stores clear to zero. The stores persist across packets; parse state
// restarts after each last byte.
module dhcp_option_lease_extractor
  import dolx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_opt_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_subnet_mask,
  output logic [31:0] out_router_addr,
  output logic [31:0] out_dns_addr,
  output logic [31:0] out_time_server_addr,
  output logic [31:0] out_lease_seconds,
  output logic [30:0] out_renew_seconds,
  output logic [31:0] out_rebind_seconds,
  output logic [4:0]  out_found_mask
);

  step_t   step;
  result_t res;
  logic    res_fire;
  logic    out_busy;

  dolx_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_opt_byte  (in_opt_byte),
    .in_last_byte (in_last_byte),
    .out_busy     (out_busy),
    .step         (step)
  );

  dolx_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .res_fire (res_fire),
    .res      (res)
  );

  dolx_out_reg u_out_reg (
    .clk                  (clk),
    .rst_n                (rst_n),
    .res_fire             (res_fire),
    .res                  (res),
    .out_busy             (out_busy),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_subnet_mask      (out_subnet_mask),
    .out_router_addr      (out_router_addr),
    .out_dns_addr         (out_dns_addr),
    .out_time_server_addr (out_time_server_addr),
    .out_lease_seconds    (out_lease_seconds),
    .out_renew_seconds    (out_renew_seconds),
    .out_rebind_seconds   (out_rebind_seconds),
    .out_found_mask       (out_found_mask)
  );

endmodule

FILE: tb/dhcp_option_lease_extractor_test.sv
// Testbench for the DHCP option lease extractor: directed and random option streams.
module dhcp_option_lease_extractor_test;
  import dolx_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT   = 3000;
  localparam int RANDOM_WORDS = 320;
  localparam int HOLDOFF_LEN  = 300;

  // One lease report as the block should deliver it
  typedef struct {
    logic [31:0] mask;
    logic [31:0] router;
    logic [31:0] dns;
    logic [31:0] tsrv;
    logic [31:0] lease;
    logic [30:0] renew;
    logic [31:0] rebind;
    logic [4:0]  found;
  } lease_report_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_opt_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_subnet_mask;
  logic [31:0] out_router_addr;
  logic [31:0] out_dns_addr;
  logic [31:0] out_time_server_addr;
  logic [31:0] out_lease_seconds;
  logic [30:0] out_renew_seconds;
  logic [31:0] out_rebind_seconds;
  logic [4:0]  out_found_mask;

  dhcp_option_lease_extractor DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_opt_byte          (in_opt_byte),
    .in_last_byte         (in_last_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_subnet_mask      (out_subnet_mask),
    .out_router_addr      (out_router_addr),
    .out_dns_addr         (out_dns_addr),
    .out_time_server_addr (out_time_server_addr),
    .out_lease_seconds    (out_lease_seconds),
    .out_renew_seconds    (out_renew_seconds),
    .out_rebind_seconds   (out_rebind_seconds),
    .out_found_mask       (out_found_mask)
  );

  // Parser shadow state
  phase_t      walk_phase;
  logic [7:0]  rec_code;
  logic [7:0]  rec_left;
  logic [7:0]  rec_index;
  logic [4:0]  seen_opts;
  logic [31:0] mask_val;
  logic [31:0] router_val;
  logic [31:0] dns_val;
  logic [31:0] tsrv_val;
  logic [31:0] lease_val;
  logic [31:0] renew_val;
  logic [31:0] rebind_val;
  logic [31:0] lease_acc;

  lease_report_t reports_due[$];
  logic [7:0]    frame_q[$];

  int fail_count  = 0;
  int words_sent  = 0;
  int idle_cycles = 0;
  bit tx_random   = 1'b1;
  bit rx_random   = 1'b1;
  int rx_hold_len = 0;

  // Clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Flag bit of an option that is kept, zero otherwise
  function automatic logic [4:0] opt_flag(input logic [7:0] code);
    if (code == CODE_MASK) return FLAG_MASK;
    if (code == CODE_ROUTER) return FLAG_ROUTER;
    if (code == CODE_DNS) return FLAG_DNS;
    if (code == CODE_TIME) return FLAG_TIME;
    if (code == CODE_LEASE) return FLAG_LEASE;
    return 5'b0;
  endfunction

  // Replace byte idx of an address, idx 0 most significant
  function automatic logic [31:0] merge_byte(input logic [31:0] w, input logic [7:0] idx,
                                             input logic [7:0] b);
    int sh;
    sh = 24 - 8 * int'(idx);
    return (w & ~(32'hFF << sh)) | ({24'b0, b} << sh);
  endfunction

  task automatic load_lease(input logic [31:0] v);
    logic [34:0] seven;
    seven      = {3'b0, v} * 35'd7;
    lease_acc  = v;
    lease_val  = v;
    renew_val  = v >> 1;
    rebind_val = seven[34:3];
  endtask

  task automatic clear_walk();
    walk_phase = PH_CODE;
    rec_code   = CODE_PAD;
    rec_left   = 8'd0;
    rec_index  = 8'd0;
    seen_opts  = 5'b0;
  endtask

  // Advance the shadow parser by one options byte; queue a report on the last one
  task automatic parse_byte(input logic [7:0] b, input logic last);
    logic [4:0]    f;
    lease_report_t rep;
    case (walk_phase)
      PH_CODE: begin
        if (b == CODE_END) begin
          walk_phase = PH_DONE;
        end else if (b != CODE_PAD) begin
          f = opt_flag(b);
          if (f != 5'b0 && (seen_opts & f) == 5'b0) begin
            seen_opts = seen_opts | f;
            rec_code  = b;
          end else begin
            rec_code = CODE_PAD;
          end
          walk_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        rec_left  = b;
        rec_index = 8'd0;
        if (rec_code == CODE_LEASE) load_lease(32'd0);
        if (b == 8'd0) walk_phase = PH_CODE;
        else walk_phase = PH_VALUE;
      end
      PH_VALUE: begin
        if (rec_code == CODE_LEASE) begin
          load_lease({lease_acc[23:0], b});
        end else if (rec_index < 8'd4) begin
          case (rec_code)
            CODE_MASK:   mask_val   = merge_byte(mask_val, rec_index, b);
            CODE_ROUTER: router_val = merge_byte(router_val, rec_index, b);
            CODE_DNS:    dns_val    = merge_byte(dns_val, rec_index, b);
            CODE_TIME:   tsrv_val   = merge_byte(tsrv_val, rec_index, b);
            default: ;
          endcase
        end
        if (rec_index != 8'd255) rec_index = rec_index + 8'd1;
        rec_left = rec_left - 8'd1;
        if (rec_left == 8'd0) walk_phase = PH_CODE;
      end
      default: ;
    endcase
    if (last) begin
      rep.mask   = mask_val;
      rep.router = router_val;
      rep.dns    = dns_val;
      rep.tsrv   = tsrv_val;
      rep.lease  = lease_val;
      rep.renew  = renew_val[30:0];
      rep.rebind = rebind_val;
      rep.found  = seen_opts;
      reports_due.push_back(rep);
      clear_walk();
    end
  endtask

  // Gap length: mostly none, some short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Send one word and wait for it to be taken
  task automatic send_word(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_random ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_opt_byte  <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_byte(b, last);
    words_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) send_word(frame_q[i], i == frame_q.size() - 1);
  endtask

  function automatic logic [7:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return CODE_PAD;
    if (r < 25) return CODE_MASK;
    if (r < 38) return CODE_ROUTER;
    if (r < 50) return CODE_DNS;
    if (r < 62) return CODE_TIME;
    if (r < 78) return CODE_LEASE;
    return 8'($urandom_range(1, 254));
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 199);
    if (r == 0) return 255;
    if (r < 20) return 0;
    if (r < 170) return $urandom_range(1, 6);
    return $urandom_range(7, 12);
  endfunction

  // Random frame: mostly well-formed records, some noise, some cut short
  task automatic build_frame();
    int         kind;
    int         len;
    int         cut;
    logic [7:0] code;
    frame_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      repeat ($urandom_range(1, 10)) frame_q.push_back(8'($urandom));
      return;
    end
    repeat ($urandom_range(1, 5)) begin
      code = pick_code();
      frame_q.push_back(code);
      if (code != CODE_PAD) begin
        len = pick_len();
        frame_q.push_back(8'(len));
        repeat (len) frame_q.push_back(pick_value());
      end
    end
    if ($urandom_range(0, 9) < 7) begin
      frame_q.push_back(CODE_END);
      repeat ($urandom_range(0, 3)) frame_q.push_back(8'($urandom));
    end
    if (kind < 25) begin
      cut = $urandom_range(1, frame_q.size());
      while (frame_q.size() > cut) void'(frame_q.pop_back());
    end
  endtask

  // Pad, full mask, one-byte router, end code and a byte after it
  task automatic test_address_records();
    frame_q = '{CODE_PAD, CODE_MASK, 8'd4, 8'hFF, 8'hFF, 8'hFF, 8'h00,
                CODE_ROUTER, 8'd1, 8'h0A, CODE_END, 8'h5A};
    send_frame();
  endtask

  // Full lease, long DNS record, packet ending inside a time server record
  task automatic test_lease_and_truncation();
    frame_q = '{CODE_LEASE, 8'd4, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                CODE_DNS, 8'd5, 8'hC0, 8'hA8, 8'h00, 8'h01, 8'h09,
                CODE_TIME, 8'd2, 8'h7F};
    send_frame();
  endtask

  // Receiver holds off while short frames keep coming, so the input backs up
  task automatic test_receiver_holdoff();
    tx_random   = 1'b0;
    rx_random   = 1'b0;
    rx_hold_len = HOLDOFF_LEN;
    repeat (20) begin
      frame_q = '{CODE_LEASE, 8'd2, pick_value(), pick_value()};
      send_frame();
    end
    tx_random = 1'b1;
    rx_random = 1'b1;
  endtask

  // Random frames, then the sender waits for every report, then a burst with no idling on either side
  task automatic test_drain_pause();
    repeat (4) begin
      build_frame();
      send_frame();
    end
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    tx_random = 1'b0;
    rx_random = 1'b0;
    repeat (6) begin
      build_frame();
      send_frame();
    end
    tx_random = 1'b1;
    rx_random = 1'b1;
  endtask

  task automatic test_random_packets();
    int goal;
    goal = words_sent + RANDOM_WORDS;
    while (words_sent < goal) begin
      build_frame();
      send_frame();
    end
  endtask

  // Receiver stall pattern
  initial begin
    int n;
    out_stall = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (rx_hold_len > 0) begin
        n           = rx_hold_len;
        rx_hold_len = 0;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end else if (!rx_random) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        n = idle_len();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] due,
                                      input logic [31:0] got);
    if (got !== due) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, due, got);
      fail_count++;
    end
  endfunction

  // Compare each taken result word with the oldest expected report
  always @(posedge clk) begin
    lease_report_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (reports_due.size() == 0) begin
        $display("%0t: result word with none expected, actual mask %h lease %h found %h",
                 $time, out_subnet_mask, out_lease_seconds, out_found_mask);
        fail_count++;
      end else begin
        due = reports_due.pop_front();
        check_field("subnet_mask", due.mask, out_subnet_mask);
        check_field("router_addr", due.router, out_router_addr);
        check_field("dns_addr", due.dns, out_dns_addr);
        check_field("time_server_addr", due.tsrv, out_time_server_addr);
        check_field("lease_seconds", due.lease, out_lease_seconds);
        check_field("renew_seconds", {1'b0, due.renew}, {1'b0, out_renew_seconds});
        check_field("rebind_seconds", due.rebind, out_rebind_seconds);
        check_field("found_mask", {27'b0, due.found}, {27'b0, out_found_mask});
      end
    end
  end

  // Watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress, %0d reports outstanding", $time, reports_due.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_opt_byte  = 8'h00;
    in_last_byte = 1'b0;
    clear_walk();
    mask_val   = 32'd0;
    router_val = 32'd0;
    dns_val    = 32'd0;
    tsrv_val   = 32'd0;
    load_lease(32'd0);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_address_records();
    test_lease_and_truncation();
    test_receiver_holdoff();
    test_drain_pause();
    test_random_packets();

    // Drain, then allow for the two-stage result path
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
